>>> rtl/psc_pkg.sv
// Shared types and codes for the square-wave channel: command codes, register
// indexes, the register set and the payload of the input and result channels.
// No dependencies.
`default_nettype none

package psc_pkg;

  localparam int CmdW   = 3;
  localparam int FreqW  = 11;
  localparam int LenW   = 8;
  localparam int VolW   = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 4;

  // Command codes carried in the command field.
  localparam logic [CmdW-1:0] CMD_TIMER   = 3'd0;
  localparam logic [CmdW-1:0] CMD_QUARTER = 3'd1;
  localparam logic [CmdW-1:0] CMD_HALF    = 3'd2;
  localparam logic [CmdW-1:0] CMD_NOTE    = 3'd3;
  localparam logic [CmdW-1:0] CMD_SOFTRST = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DUTY_SELECT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CONSTANT_VOLUME = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VOLUME_PERIOD   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_HALT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_ENABLE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_PERIOD    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_SHIFT     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SWEEP_NEGATE    = 3'd7;

  typedef struct packed {
    logic [1:0]      duty_select;
    logic            constant_volume;
    logic [VolW-1:0] volume_period;
    logic            length_halt;
    logic            sweep_enable;
    logic [2:0]      sweep_period;
    logic [2:0]      sweep_shift;
    logic            sweep_negate;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic             frame_clocking_length;
    logic [FreqW-1:0] note_period;
    logic [LenW-1:0]  note_length;
    logic             channel_enable;
  } in_item_t;

  typedef struct packed {
    logic [VolW-1:0] sample;
    logic            sample_ready;
    logic            length_active;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/psc_if.sv
// Valid/ready channel interfaces for the command items and the result items.
// Depends on psc_pkg for the payload types.
`default_nettype none

interface psc_in_if;
  logic               valid;
  logic               ready;
  psc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psc_out_if;
  logic               valid;
  logic               ready;
  psc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/psc_cfg.sv
// Configuration register bank of the square-wave channel.
// Depends on psc_pkg for the register indexes and the register set type.
`default_nettype none

module psc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [psc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [psc_pkg::CfgDataW-1:0]  cfg_data,
  output psc_pkg::cfg_t                      cfg
);

  psc_pkg::cfg_t cfg_r;
  psc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        psc_pkg::REG_DUTY_SELECT:     cfg_nxt.duty_select     = cfg_data[1:0];
        psc_pkg::REG_CONSTANT_VOLUME: cfg_nxt.constant_volume = cfg_data[0];
        psc_pkg::REG_VOLUME_PERIOD:   cfg_nxt.volume_period   = cfg_data;
        psc_pkg::REG_LENGTH_HALT:     cfg_nxt.length_halt     = cfg_data[0];
        psc_pkg::REG_SWEEP_ENABLE:    cfg_nxt.sweep_enable    = cfg_data[0];
        psc_pkg::REG_SWEEP_PERIOD:    cfg_nxt.sweep_period    = cfg_data[2:0];
        psc_pkg::REG_SWEEP_SHIFT:     cfg_nxt.sweep_shift     = cfg_data[2:0];
        psc_pkg::REG_SWEEP_NEGATE:    cfg_nxt.sweep_negate    = cfg_data[0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/psc_core.sv
// Channel state and its single-pass update: timer, duty sequencer, envelope,
// length counter and sweep. Depends on psc_pkg for command codes and types.
`default_nettype none

module psc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  psc_pkg::in_item_t    item,
  input  psc_pkg::cfg_t        cfg,
  output psc_pkg::out_item_t   result
);

  typedef struct packed {
    logic [psc_pkg::FreqW-1:0] frequency;
    logic [12:0]               timer_count;
    logic [2:0]                duty_step;
    logic [3:0]                env_level;
    logic [4:0]                env_divider;
    logic                      env_start;
    logic [3:0]                volume_out;
    logic [psc_pkg::LenW-1:0]  length_count;
    logic [psc_pkg::LenW-1:0]  length_reload_value;
    logic                      length_reload_pending;
    logic                      length_reload_allowed;
    logic [3:0]                sweep_divider;
    logic                      sweep_restart;
    logic [3:0]                level_out;
    logic                      halt_latched;
  } state_t;

  state_t st_r;
  state_t st_nxt;
  logic   stepped;
  logic [psc_pkg::LenW-1:0]  len_tmp;
  logic [3:0]                sdiv_tmp;
  logic [psc_pkg::FreqW-1:0] delta;
  logic [11:0]               period_plus1;

  // Frequency is usable when it is at least eight and, when adding, the
  // swept target stays below the eleven-bit limit.
  function automatic logic freq_valid(input logic [10:0] freq, input logic [2:0] shift,
                                      input logic negate);
    logic [11:0] sum;
    sum = {1'b0, freq} + {1'b0, (freq >> shift)};
    return (freq >= 11'd8) && (negate || !sum[11]);
  endfunction

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] pattern;
    case (sel)
      2'd0:    pattern = 8'b0000_0010;
      2'd1:    pattern = 8'b0000_0110;
      2'd2:    pattern = 8'b0001_1110;
      default: pattern = 8'b1111_1001;
    endcase
    return pattern[step];
  endfunction

  assign delta        = st_r.frequency >> cfg.sweep_shift;
  assign period_plus1 = {1'b0, st_r.frequency} + 12'd1;

  always_comb begin
    st_nxt   = st_r;
    stepped  = 1'b0;
    len_tmp  = st_r.length_count;
    sdiv_tmp = st_r.sweep_divider - 4'd1;
    if (accept) begin
      case (item.command)
        psc_pkg::CMD_TIMER: begin
          st_nxt.halt_latched = cfg.length_halt;
          if (st_r.length_reload_pending && st_r.length_reload_allowed &&
              !(item.frame_clocking_length && (st_r.length_count != '0))) begin
            len_tmp = st_r.length_reload_value;
          end
          st_nxt.length_count          = len_tmp;
          st_nxt.length_reload_pending = 1'b0;
          if (st_r.timer_count <= 13'd1) begin
            stepped              = 1'b1;
            st_nxt.timer_count   = {period_plus1, 1'b0};
            st_nxt.duty_step     = st_r.duty_step + 3'd1;
            if ((len_tmp != '0) &&
                freq_valid(st_r.frequency, cfg.sweep_shift, cfg.sweep_negate) &&
                duty_bit(cfg.duty_select, st_nxt.duty_step)) begin
              st_nxt.level_out = st_r.volume_out;
            end else begin
              st_nxt.level_out = 4'd0;
            end
          end else begin
            st_nxt.timer_count = st_r.timer_count - 13'd1;
          end
        end
        psc_pkg::CMD_QUARTER: begin
          if (st_r.env_start) begin
            st_nxt.env_start   = 1'b0;
            st_nxt.env_level   = 4'hF;
            st_nxt.env_divider = {1'b0, cfg.volume_period} + 5'd1;
          end else if (st_r.env_divider != 5'd0) begin
            st_nxt.env_divider = st_r.env_divider - 5'd1;
          end else begin
            st_nxt.env_divider = {1'b0, cfg.volume_period} + 5'd1;
            if (st_r.env_level != 4'd0) begin
              st_nxt.env_level = st_r.env_level - 4'd1;
            end else if (st_r.halt_latched) begin
              st_nxt.env_level = 4'hF;
            end
          end
          st_nxt.volume_out = cfg.constant_volume ? cfg.volume_period : st_nxt.env_level;
        end
        psc_pkg::CMD_HALF: begin
          if (!st_r.halt_latched && (st_r.length_count != '0)) begin
            st_nxt.length_count = st_r.length_count - 8'd1;
          end
          st_nxt.sweep_divider = sdiv_tmp;
          if (sdiv_tmp == 4'd0) begin
            st_nxt.sweep_divider = {1'b0, cfg.sweep_period} + 4'd1;
            if (cfg.sweep_enable && (cfg.sweep_shift != 3'd0) &&
                freq_valid(st_r.frequency, cfg.sweep_shift, cfg.sweep_negate)) begin
              st_nxt.frequency = cfg.sweep_negate ? (st_r.frequency - delta)
                                                  : (st_r.frequency + delta);
            end
          end
          if (st_r.sweep_restart) begin
            st_nxt.sweep_restart = 1'b0;
            st_nxt.sweep_divider = {1'b0, cfg.sweep_period} + 4'd1;
          end
        end
        psc_pkg::CMD_NOTE: begin
          st_nxt.frequency             = item.note_period;
          st_nxt.length_reload_value   = item.note_length;
          st_nxt.length_reload_allowed = item.channel_enable;
          st_nxt.length_reload_pending = 1'b1;
          st_nxt.env_start             = 1'b1;
          st_nxt.sweep_restart         = 1'b1;
        end
        psc_pkg::CMD_SOFTRST: begin
          st_nxt.length_count          = '0;
          st_nxt.length_reload_allowed = 1'b0;
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign result.sample        = st_nxt.level_out;
  assign result.sample_ready  = stepped;
  assign result.length_active = (st_nxt.length_count != '0);

endmodule

`default_nettype wire

>>> rtl/pulse_square_channel.sv
// Top level of the square-wave channel: register bank, channel state and the
// result register. Depends on psc_pkg, psc_if, psc_cfg and psc_core.
`default_nettype none

// Usage
// The block takes one command item at a time on in_ch (timer tick, quarter
// frame, half frame, note start or soft reset) and returns exactly one
// result item on out_ch for each: the channel level, a flag that the duty
// sequencer stepped on that item, and whether the length counter is running.
// The result is registered: an item accepted in one cycle has its result
// valid on out_ch in the next cycle. Throughput is one item per cycle
// while the receiver takes each result, set by the state update in psc_core,
// a closed loop since every command works on the state left by the one before.
// The result register parts the two channels: in_ch.ready is high whenever
// the result register is empty or its item is being taken in the same cycle.
// When the receiver stalls, the held result stays stable and in_ch.ready
// falls until it is taken, so no item is lost or repeated.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data while the channel is idle; a write takes effect once registered.
// Synchronous reset (rst_n low) clears the channel state, the configuration
// and the valid flag of the result register, but not its payload; the first
// timer tick after reset steps the sequencer at once.

module pulse_square_channel (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  psc_in_if.sink                             in_ch,
  psc_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [psc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [psc_pkg::CfgDataW-1:0]  cfg_data
);

  psc_pkg::cfg_t      cfg;
  psc_pkg::out_item_t result;
  psc_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               accept;

  // An item enters whenever the result register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  psc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_ch.data),
    .cfg    (cfg),
    .result (result)
  );

  // The result register holds its item until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset; it is loaded with every accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/psc_checker.sv
// Port-level checks of the square-wave channel, bound to its top level.
// Depends on psc_pkg for the command codes and payload types.
`default_nettype none

module psc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input psc_pkg::in_item_t       in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input psc_pkg::out_item_t      out_data
);

  // A waiting result keeps its values until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result item changed or vanished");

  // An accepted item always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // The block never stalls its source while the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  // Only a timer tick can step the sequencer.
  a_step_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.command != psc_pkg::CMD_TIMER))
      |=> !out_data.sample_ready)
    else $error("sequencer stepped on a command other than a timer tick");

  // A soft reset always leaves the length counter stopped.
  a_softrst_clears_length: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.command == psc_pkg::CMD_SOFTRST))
      |=> !out_data.length_active)
    else $error("length counter still running after a soft reset");

endmodule

bind pulse_square_channel psc_checker u_psc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_data   (in_ch.data),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
